[sv/srdb_pkg.sv]
package srdb_pkg;

  // Default geometry
  localparam int DEF_NUM_SETS       = 2048;
  localparam int DEF_NUM_WAYS       = 16;
  localparam int DEF_SIG_ENTRIES    = 64;
  localparam int DEF_SELECTOR_WIDTH = 10;
  localparam int DEF_LEADER_SETS    = 32;

  // Field widths of the channels
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 8;
  localparam int SIG_RAW_W = 6;

  // Access counter and decay period register
  localparam int CNT_W        = 20;
  localparam int DECAY_W      = 5;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 5'd11;
  localparam logic [DECAY_W-1:0] DECAY_MAX   = 5'd20;

  // Re-reference values and 2-bit counter levels
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_DIST  = 2'd3;
  localparam logic [1:0] CTR_MAX    = 2'd3;
  localparam logic [1:0] CTR_HOT    = 2'd2;
  localparam logic [1:0] SIG_CTR_RESET = 2'd1;

  // Item kinds
  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

endpackage

[sv/srdb_if.sv]
interface srdb_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [10:0] set_index;
  logic [3:0] way_index;
  logic [7:0] pc_bits;
  logic       hit;

  modport source (output valid, func, set_index, way_index, pc_bits, hit, input ready);
  modport sink   (input valid, func, set_index, way_index, pc_bits, hit, output ready);
endinterface

interface srdb_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic       is_victim_reply;

  modport source (output valid, victim_way, is_victim_reply, input ready);
  modport sink   (input valid, victim_way, is_victim_reply, output ready);
endinterface

[sv/signature_rrip_deadblock_replacement.sv]
// Channel  Dir  Payload                                       Handshake
// req      in   func, set_index, way_index, pc_bits, hit       valid/ready
// rsp      out  victim_way, is_victim_reply                    valid/ready
// cfg      in   cfg_wdata (decay period log2)                  cfg_we
//
// A query steps through S_RED, S_Q_RD, S_Q_EV and S_DONE; an update through
// S_RED, S_CNT, S_U_RD, S_U_OLD, S_U_OLDW and, on a miss fill, S_U_SIGRD and
// S_U_FIN before S_DONE. S_RED repeats once per range fold of set_index/way_index.
// One row read and one row write per set go through a single-port row memory.
// An update that hits a decay period adds a sweep that reads and writes back each row.
// After rst a clearing pass over max(NUM_SETS, SIG_ENTRIES) entries runs with
// req.ready low. A stalled response holds the block in its final step.
module signature_rrip_deadblock_replacement #(
  parameter int NUM_SETS       = srdb_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS       = srdb_pkg::DEF_NUM_WAYS,
  parameter int SIG_ENTRIES    = srdb_pkg::DEF_SIG_ENTRIES,
  parameter int SELECTOR_WIDTH = srdb_pkg::DEF_SELECTOR_WIDTH,
  parameter int LEADER_SETS    = srdb_pkg::DEF_LEADER_SETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srdb_pkg::DECAY_W-1:0]   cfg_wdata,
  srdb_req_if.sink                       req,
  srdb_rsp_if.source                     rsp
);
  import srdb_pkg::*;

  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = $clog2(NUM_WAYS);
  localparam int GW = $clog2(SIG_ENTRIES);
  localparam int CLR_LEN = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
  localparam int CW = $clog2(CLR_LEN + 1);
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = SELECTOR_WIDTH'(1) << (SELECTOR_WIDTH - 1);
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;

  typedef struct packed {
    logic [NUM_WAYS-1:0][GW-1:0] sig;
    logic [NUM_WAYS-1:0][1:0]    dead;
    logic [NUM_WAYS-1:0][1:0]    rrpv;
  } row_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RED, S_Q_RD, S_Q_EV, S_CNT, S_DK_RD, S_DK_WR,
    S_U_RD, S_U_OLD, S_U_OLDW, S_U_SIGRD, S_U_FIN, S_DONE
  } state_t;

  state_t state;

  // Row memory and signature counter table
  row_t       rows [NUM_SETS];
  logic [1:0] sig_ctr [SIG_ENTRIES];
  row_t       row_q;
  logic [1:0] sig_q;

  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  row_t          mem_wdata, row_dflt;
  logic          sig_we, sig_re;
  logic [GW-1:0] sig_waddr, sig_raddr;
  logic [1:0]    sig_wdata;

  // Item registers
  logic                  func_r, hit_r;
  logic [SET_IN_W-1:0]   set_r;
  logic [WAY_IN_W-1:0]   way_r;
  logic [PC_W-1:0]       pc_r;

  logic [DECAY_W-1:0]        decay_log2;
  logic [CNT_W-1:0]          access_count;
  logic [SELECTOR_WIDTH-1:0] selector;
  logic [CW-1:0]             clr_idx;
  logic [SW-1:0]             dk_idx;

  logic       out_valid;
  logic [3:0] out_way;
  logic       out_vic;
  logic [3:0] res_way;
  logic       res_vic;

  // Derived per-item values
  logic [SW-1:0] row_addr;
  logic [WW-1:0] way_sel;
  logic [GW-1:0] sig, old_sig;
  logic          set_big, way_big;
  logic          lead_srrip, lead_sig, use_sig;
  logic [1:0]    dead_n, cur_dead;
  logic [CNT_W-1:0] cnt_next, cnt_mask;
  logic [DECAY_W-1:0] k;
  logic          decay_due;
  logic [1:0]    ins_rrpv;
  row_t          row_dec;

  logic [NUM_WAYS-1:0][1:0] aged;
  logic                     need_age;
  logic [WW-1:0]            victim;

  srdb_victim #(.NUM_WAYS(NUM_WAYS), .WW(WW)) u_victim (
    .rrpv     (row_q.rrpv),
    .aged     (aged),
    .need_age (need_age),
    .victim   (victim)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.victim_way  = out_way;
  assign rsp.is_victim_reply = out_vic;

  // Item decode
  always_comb begin
    set_big    = 17'(set_r) >= 17'(NUM_SETS);
    way_big    = 6'(way_r) >= 6'(NUM_WAYS);
    row_addr   = SW'(set_r);
    way_sel    = WW'(way_r);
    sig        = GW'(SIG_RAW_W'(pc_r >> 2) ^ set_r[SIG_RAW_W-1:0]);
    old_sig    = row_q.sig[way_sel];
    lead_srrip = 17'(set_r) < 17'(LEADER_SETS);
    lead_sig   = !lead_srrip && (18'(set_r) < 18'(2 * LEADER_SETS));
    use_sig    = lead_srrip ? 1'b0 : (lead_sig ? 1'b1 : (selector < SEL_MID));
    k          = (decay_log2 > DECAY_MAX) ? DECAY_MAX : decay_log2;
    cnt_next   = access_count + CNT_W'(1);
    cnt_mask   = CNT_W'((21'(1) << k) - 21'(1));
    decay_due  = (cnt_next & cnt_mask) == '0;
    cur_dead   = row_q.dead[way_sel];
    dead_n     = (cur_dead == CTR_MAX) ? CTR_MAX : cur_dead + 2'd1;
  end

  // Insertion value on a miss fill
  always_comb begin
    if (use_sig) begin
      if (dead_n >= CTR_HOT && sig_q < CTR_HOT) ins_rrpv = RRPV_DIST;
      else if (sig_q >= CTR_HOT && dead_n < CTR_HOT) ins_rrpv = RRPV_NEAR;
      else ins_rrpv = RRPV_LONG;
    end else begin
      ins_rrpv = (sig_q >= CTR_HOT) ? RRPV_NEAR : RRPV_LONG;
    end
  end

  // Reset row and decayed row
  always_comb begin
    row_dflt = '0;
    row_dec  = row_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_dflt.rrpv[w] = RRPV_LONG;
      if (row_q.dead[w] != 2'd0) row_dec.dead[w] = row_q.dead[w] - 2'd1;
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = row_addr;
    mem_raddr = row_addr;
    mem_wdata = row_q;
    sig_we    = 1'b0;
    sig_re    = 1'b0;
    sig_waddr = old_sig;
    sig_raddr = old_sig;
    sig_wdata = sig_q;
    case (state)
      S_CLR: begin
        mem_we    = 32'(clr_idx) < NUM_SETS;
        mem_waddr = SW'(clr_idx);
        mem_wdata = row_dflt;
        sig_we    = 32'(clr_idx) < SIG_ENTRIES;
        sig_waddr = GW'(clr_idx);
        sig_wdata = SIG_CTR_RESET;
      end
      S_Q_RD, S_U_RD: mem_re = 1'b1;
      S_Q_EV: begin
        mem_we = need_age;
        mem_wdata.rrpv = aged;
      end
      S_DK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = dk_idx;
      end
      S_DK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dk_idx;
        mem_wdata = row_dec;
      end
      S_U_OLD: sig_re = 1'b1;
      S_U_OLDW: begin
        sig_we = 1'b1;
        if (hit_r) begin
          sig_wdata = (sig_q == CTR_MAX) ? CTR_MAX : sig_q + 2'd1;
          mem_we = 1'b1;
          mem_wdata.rrpv[way_sel] = RRPV_NEAR;
          mem_wdata.dead[way_sel] = 2'd0;
        end else begin
          sig_wdata = (sig_q == 2'd0) ? 2'd0 : sig_q - 2'd1;
        end
      end
      S_U_SIGRD: begin
        sig_re    = 1'b1;
        sig_raddr = sig;
      end
      S_U_FIN: begin
        mem_we = 1'b1;
        mem_wdata.sig[way_sel]  = sig;
        mem_wdata.dead[way_sel] = dead_n;
        mem_wdata.rrpv[way_sel] = ins_rrpv;
      end
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (mem_we) rows[mem_waddr] <= mem_wdata;
    if (mem_re) row_q <= rows[mem_raddr];
    if (sig_we) sig_ctr[sig_waddr] <= sig_wdata;
    if (sig_re) sig_q <= sig_ctr[sig_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      dk_idx       <= '0;
      decay_log2   <= DECAY_RESET;
      access_count <= '0;
      selector     <= SEL_MID;
      out_valid    <= 1'b0;
      res_way      <= '0;
      res_vic      <= 1'b0;
    end else begin
      if (cfg_we) decay_log2 <= cfg_wdata;
      // S_DONE reloads the output register itself
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == CW'(CLR_LEN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            func_r <= req.func;
            set_r  <= req.set_index;
            way_r  <= req.way_index;
            pc_r   <= req.pc_bits;
            hit_r  <= req.hit;
            state  <= S_RED;
          end
        end
        S_RED: begin
          if (set_big) set_r <= set_r - SET_IN_W'(NUM_SETS);
          if (way_big) way_r <= way_r - WAY_IN_W'(NUM_WAYS);
          if (!set_big && !way_big) state <= (func_r == FUNC_QUERY) ? S_Q_RD : S_CNT;
        end
        S_Q_RD: state <= S_Q_EV;
        S_Q_EV: begin
          res_way <= 4'(victim);
          res_vic <= 1'b1;
          state   <= S_DONE;
        end
        S_CNT: begin
          access_count <= cnt_next;
          dk_idx <= '0;
          state  <= decay_due ? S_DK_RD : S_U_RD;
        end
        S_DK_RD: state <= S_DK_WR;
        S_DK_WR: begin
          dk_idx <= dk_idx + SW'(1);
          state  <= (dk_idx == SW'(NUM_SETS - 1)) ? S_U_RD : S_DK_RD;
        end
        S_U_RD:  state <= S_U_OLD;
        S_U_OLD: state <= S_U_OLDW;
        S_U_OLDW: begin
          res_way <= '0;
          res_vic <= 1'b0;
          state   <= hit_r ? S_DONE : S_U_SIGRD;
        end
        S_U_SIGRD: state <= S_U_FIN;
        S_U_FIN: begin
          if (use_sig) begin
            if (ins_rrpv == RRPV_DIST && lead_sig && selector != SEL_MAX)
              selector <= selector + SELECTOR_WIDTH'(1);
          end else if (lead_srrip && sig_q >= CTR_HOT && selector != '0) begin
            selector <= selector - SELECTOR_WIDTH'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_way   <= res_way;
            out_vic   <= res_vic;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/srdb_victim.sv]
module srdb_victim #(
  parameter int NUM_WAYS = srdb_pkg::DEF_NUM_WAYS,
  parameter int WW       = $clog2(NUM_WAYS)
) (
  input  logic [NUM_WAYS-1:0][1:0] rrpv,
  output logic [NUM_WAYS-1:0][1:0] aged,
  output logic                     need_age,
  output logic [WW-1:0]            victim
);
  import srdb_pkg::*;

  logic [3:0] seen;
  logic [1:0] top;
  logic [1:0] add;

  // Which levels occur in the set
  always_comb begin
    seen = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      seen[rrpv[w]] = 1'b1;
    end
  end

  // Highest level present, and the aging step that lifts it to distant
  always_comb begin
    if (seen[3]) top = 2'd3;
    else if (seen[2]) top = 2'd2;
    else if (seen[1]) top = 2'd1;
    else top = 2'd0;
    add = RRPV_DIST - top;
    need_age = (add != 2'd0);
  end

  // Aged row and lowest-numbered way at the top level
  always_comb begin
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged[w] = rrpv[w] + add;
      if (rrpv[w] == top) victim = WW'(w);
    end
  end

endmodule

[tb/signature_rrip_deadblock_replacement_tb.sv]
`timescale 1ns / 100ps

module signature_rrip_deadblock_replacement_tb;
  import srdb_pkg::*;

  localparam int SETS       = DEF_NUM_SETS;
  localparam int WAYS       = DEF_NUM_WAYS;
  localparam int SIGS       = DEF_SIG_ENTRIES;
  localparam int SEL_W      = DEF_SELECTOR_WIDTH;
  localparam int LEADERS    = DEF_LEADER_SETS;
  localparam int LINE_COUNT = SETS * WAYS;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic                func;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [PC_W-1:0]     pc_bits;
    logic                hit;
  } access_t;

  typedef struct {
    logic [3:0] victim_way;
    logic       is_victim_reply;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DECAY_W-1:0] cfg_wdata = '0;

  srdb_req_if req_ch ();
  srdb_rsp_if rsp_ch ();

  signature_rrip_deadblock_replacement dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Replacement state mirror
  logic [1:0]       rrpv_m [LINE_COUNT];
  logic [5:0]       lsig_m [LINE_COUNT];
  logic [1:0]       dead_m [LINE_COUNT];
  logic [1:0]       sctr_m [SIGS];
  logic [SEL_W-1:0] selector_m;
  logic [CNT_W-1:0] access_cnt_m;
  logic [DECAY_W-1:0] decay_log2_m;

  access_t pending_items[$];
  reply_t  expected_replies[$];
  access_t cur_item;
  int errors = 0;
  int queries_sent = 0;
  int updates_sent = 0;
  int cycles = 0;
  int idle_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Victim search with set-wide aging
  function automatic logic [3:0] choose_victim(input int base);
    int top;
    int add;
    top = 0;
    for (int w = 0; w < WAYS; w++)
      if (rrpv_m[base + w] > top) top = rrpv_m[base + w];
    if (top < 3) begin
      add = 3 - top;
      for (int w = 0; w < WAYS; w++) rrpv_m[base + w] = rrpv_m[base + w] + add;
    end
    for (int w = 0; w < WAYS; w++)
      if (rrpv_m[base + w] == RRPV_DIST) return w[3:0];
    return 4'd0;
  endfunction

  // Access update: decay, signature training and insertion choice
  function automatic void apply_access(input int set, input int way, input int pc,
                                       input bit hit);
    int k;
    int line;
    int sg;
    int old;
    bit lead_srrip;
    bit lead_sig;
    bit use_sig;
    bit hot;
    k = (decay_log2_m > DECAY_MAX) ? DECAY_MAX : decay_log2_m;
    line = set * WAYS + way;
    lead_srrip = set < LEADERS;
    lead_sig = !lead_srrip && set < 2 * LEADERS;
    access_cnt_m = access_cnt_m + 1'b1;
    if ((int'(access_cnt_m) & ((1 << k) - 1)) == 0)
      for (int i = 0; i < LINE_COUNT; i++)
        if (dead_m[i] != 0) dead_m[i] = dead_m[i] - 1'b1;
    sg = ((pc >> 2) ^ (set & 6'h3F)) & (SIGS - 1);
    old = lsig_m[line] & (SIGS - 1);
    if (hit) begin
      if (sctr_m[old] < CTR_MAX) sctr_m[old] = sctr_m[old] + 1'b1;
      dead_m[line] = 2'd0;
      rrpv_m[line] = RRPV_NEAR;
      return;
    end
    if (sctr_m[old] > 0) sctr_m[old] = sctr_m[old] - 1'b1;
    lsig_m[line] = sg[5:0];
    if (dead_m[line] < CTR_MAX) dead_m[line] = dead_m[line] + 1'b1;
    if (lead_srrip) use_sig = 1'b0;
    else if (lead_sig) use_sig = 1'b1;
    else use_sig = selector_m < (1 << (SEL_W - 1));
    if (use_sig) begin
      if (dead_m[line] >= 2 && sctr_m[sg] <= 1) begin
        rrpv_m[line] = RRPV_DIST;
        if (lead_sig && selector_m != '1) selector_m = selector_m + 1'b1;
      end else if (sctr_m[sg] >= CTR_HOT && dead_m[line] <= 1) begin
        rrpv_m[line] = RRPV_NEAR;
      end else begin
        rrpv_m[line] = RRPV_LONG;
      end
    end else begin
      hot = sctr_m[sg] >= CTR_HOT;
      rrpv_m[line] = hot ? RRPV_NEAR : RRPV_LONG;
      if (lead_srrip && hot && selector_m != 0) selector_m = selector_m - 1'b1;
    end
  endfunction

  function automatic reply_t predict_reply(input access_t it);
    reply_t r;
    if (it.func == FUNC_QUERY) begin
      r.victim_way = choose_victim(int'(it.set_index) % SETS * WAYS);
      r.is_victim_reply = 1'b1;
    end else begin
      apply_access(int'(it.set_index) % SETS, int'(it.way_index) % WAYS,
                   it.pc_bits, it.hit);
      r.victim_way = 4'd0;
      r.is_victim_reply = 1'b0;
    end
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        expected_replies.push_back(predict_reply(cur_item));
        if (cur_item.func == FUNC_QUERY) queries_sent++;
        else updates_sent++;
      end
      if (idle_left > 0) begin
        idle_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 7);
        req_ch.valid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.func      <= cur_item.func;
        req_ch.set_index <= cur_item.set_index;
        req_ch.way_index <= cur_item.way_index;
        req_ch.pc_bits   <= cur_item.pc_bits;
        req_ch.hit       <= cur_item.hit;
      end
    end
  end

  // Reply monitor and backpressure
  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no item outstanding");
        end else begin
          e = expected_replies.pop_front();
          if (rsp_ch.is_victim_reply !== e.is_victim_reply)
            report_mismatch($sformatf("is_victim_reply %0b, want %0b",
                                      rsp_ch.is_victim_reply, e.is_victim_reply));
          if (rsp_ch.victim_way !== e.victim_way)
            report_mismatch($sformatf("victim_way %0d, want %0d",
                                      rsp_ch.victim_way, e.victim_way));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_item(input bit f, input int s, input int w, input int pc,
                           input bit h);
    access_t it;
    it.func = f;
    it.set_index = s[SET_IN_W-1:0];
    it.way_index = w[WAY_IN_W-1:0];
    it.pc_bits = pc[PC_W-1:0];
    it.hit = h;
    pending_items.push_back(it);
  endtask

  // Mostly a few hot sets and PCs so lines get refilled, hit and queried
  task automatic push_random(input int n);
    int s;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) s = $urandom_range(0, 3);
      else if (r < 45) s = $urandom_range(32, 35);
      else if (r < 75) s = 64 + $urandom_range(0, 3) * 300;
      else s = $urandom_range(0, SETS - 1);
      push_item($urandom_range(0, 99) >= 30, s,
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                ($urandom_range(0, 1) != 0) ? ($urandom_range(0, 3) << 2)
                                            : $urandom_range(0, 255),
                $urandom_range(0, 1));
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_replies.size() != 0 || req_ch.valid)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_decay(input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[DECAY_W-1:0];
    decay_log2_m = v[DECAY_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_QUERY;
    req_ch.set_index = '0;
    req_ch.way_index = '0;
    req_ch.pc_bits = '0;
    req_ch.hit = 1'b0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      rrpv_m[i] = RRPV_LONG;
      lsig_m[i] = '0;
      dead_m[i] = '0;
    end
    for (int i = 0; i < SIGS; i++) sctr_m[i] = SIG_CTR_RESET;
    selector_m = 1 << (SEL_W - 1);
    access_cnt_m = '0;
    decay_log2_m = DECAY_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: aging query, hits, miss fills in both leader groups and followers
    push_item(FUNC_QUERY, 0, 0, 0, 0);
    push_item(FUNC_QUERY, 0, 0, 0, 0);
    push_item(FUNC_UPDATE, 0, 0, 0, 1);
    push_item(FUNC_QUERY, 0, 0, 0, 0);
    push_item(FUNC_UPDATE, 0, 0, 0, 0);
    push_item(FUNC_UPDATE, 0, 0, 0, 0);
    push_item(FUNC_UPDATE, 31, 15, 255, 0);
    push_item(FUNC_UPDATE, 32, 3, 128, 0);
    push_item(FUNC_UPDATE, 32, 3, 128, 0);
    push_item(FUNC_UPDATE, 32, 3, 128, 0);
    push_item(FUNC_QUERY, 32, 0, 0, 0);
    push_item(FUNC_UPDATE, 63, 7, 252, 1);
    push_item(FUNC_UPDATE, 64, 0, 0, 0);
    push_item(FUNC_UPDATE, 2047, 15, 255, 1);
    push_item(FUNC_UPDATE, 2047, 15, 255, 0);
    push_item(FUNC_QUERY, 2047, 15, 255, 1);
    push_item(FUNC_UPDATE, 1024, 8, 85, 1);
    push_item(FUNC_UPDATE, 1024, 8, 170, 0);
    push_item(FUNC_QUERY, 1024, 15, 255, 1);
    push_random(100);
    drain();

    // Decay sweeps on every update, then register extremes
    write_decay(0);
    push_random(8);
    drain();
    write_decay(1);
    push_random(30);
    drain();
    write_decay(31);
    push_random(80);
    drain();
    write_decay(20);
    push_random(80);
    drain();
    write_decay(3);
    push_random(130);
    drain();
    write_decay(2);
    quiet = 1'b1;
    push_random(100);
    drain();

    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never came", expected_replies.size()));
    $display("covered %0d victim queries and %0d updates, decay log2 0..31",
             queries_sent, updates_sent);
    $display("final selector %0d, %0d mismatches", selector_m, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
